FILE: rtl/bhd_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bhd_pkg: shared constants and functions for the header double hash
// Round constants, initial hash value and the SHA-256 round and schedule
// functions used by the pipelined compression units.
// ----------------------------------------------------------------------------
package bhd_pkg;

  localparam int unsigned Rounds = 64;
  localparam int unsigned InWidth = 640;
  localparam int unsigned OutWidth = 256;

  typedef logic [31:0] word_t;
  typedef logic [255:0] state_t;
  typedef logic [511:0] sched_t;

  localparam logic [255:0] Iv = {
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  function automatic word_t k_of(input logic [5:0] idx);
    word_t k;
    unique case (idx)
      6'd0: k = 32'h428a2f98;  6'd1: k = 32'h71374491;
      6'd2: k = 32'hb5c0fbcf;  6'd3: k = 32'he9b5dba5;
      6'd4: k = 32'h3956c25b;  6'd5: k = 32'h59f111f1;
      6'd6: k = 32'h923f82a4;  6'd7: k = 32'hab1c5ed5;
      6'd8: k = 32'hd807aa98;  6'd9: k = 32'h12835b01;
      6'd10: k = 32'h243185be; 6'd11: k = 32'h550c7dc3;
      6'd12: k = 32'h72be5d74; 6'd13: k = 32'h80deb1fe;
      6'd14: k = 32'h9bdc06a7; 6'd15: k = 32'hc19bf174;
      6'd16: k = 32'he49b69c1; 6'd17: k = 32'hefbe4786;
      6'd18: k = 32'h0fc19dc6; 6'd19: k = 32'h240ca1cc;
      6'd20: k = 32'h2de92c6f; 6'd21: k = 32'h4a7484aa;
      6'd22: k = 32'h5cb0a9dc; 6'd23: k = 32'h76f988da;
      6'd24: k = 32'h983e5152; 6'd25: k = 32'ha831c66d;
      6'd26: k = 32'hb00327c8; 6'd27: k = 32'hbf597fc7;
      6'd28: k = 32'hc6e00bf3; 6'd29: k = 32'hd5a79147;
      6'd30: k = 32'h06ca6351; 6'd31: k = 32'h14292967;
      6'd32: k = 32'h27b70a85; 6'd33: k = 32'h2e1b2138;
      6'd34: k = 32'h4d2c6dfc; 6'd35: k = 32'h53380d13;
      6'd36: k = 32'h650a7354; 6'd37: k = 32'h766a0abb;
      6'd38: k = 32'h81c2c92e; 6'd39: k = 32'h92722c85;
      6'd40: k = 32'ha2bfe8a1; 6'd41: k = 32'ha81a664b;
      6'd42: k = 32'hc24b8b70; 6'd43: k = 32'hc76c51a3;
      6'd44: k = 32'hd192e819; 6'd45: k = 32'hd6990624;
      6'd46: k = 32'hf40e3585; 6'd47: k = 32'h106aa070;
      6'd48: k = 32'h19a4c116; 6'd49: k = 32'h1e376c08;
      6'd50: k = 32'h2748774c; 6'd51: k = 32'h34b0bcb5;
      6'd52: k = 32'h391c0cb3; 6'd53: k = 32'h4ed8aa4a;
      6'd54: k = 32'h5b9cca4f; 6'd55: k = 32'h682e6ff3;
      6'd56: k = 32'h748f82ee; 6'd57: k = 32'h78a5636f;
      6'd58: k = 32'h84c87814; 6'd59: k = 32'h8cc70208;
      6'd60: k = 32'h90befffa; 6'd61: k = 32'ha4506ceb;
      6'd62: k = 32'hbef9a3f7; 6'd63: k = 32'hc67178f2;
      default: k = 32'h0;
    endcase
    return k;
  endfunction

  function automatic word_t rotr(input word_t x, input int unsigned n);
    return (x >> n) | (x << (32 - n));
  endfunction

  // One compression round; state packed a in the top word down to h.
  function automatic state_t sha_round(input state_t s, input word_t k, input word_t w);
    word_t a, b, c, d, e, f, g, h, t1, t2;
    a = s[255:224]; b = s[223:192]; c = s[191:160]; d = s[159:128];
    e = s[127:96];  f = s[95:64];   g = s[63:32];   h = s[31:0];
    t1 = h + (rotr(e, 6) ^ rotr(e, 11) ^ rotr(e, 25)) + ((e & f) ^ (~e & g)) + k + w;
    t2 = (rotr(a, 2) ^ rotr(a, 13) ^ rotr(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));
    return {t1 + t2, a, b, c, d + t1, e, f, g};
  endfunction

  // Schedule window shift; w[i] in the top word, w[i+15] in the bottom.
  function automatic sched_t sched_next(input sched_t w);
    word_t w0, w1, w9, w14, s0, s1;
    w0 = w[511:480]; w1 = w[479:448]; w9 = w[223:192]; w14 = w[63:32];
    s0 = rotr(w1, 7) ^ rotr(w1, 18) ^ (w1 >> 3);
    s1 = rotr(w14, 17) ^ rotr(w14, 19) ^ (w14 >> 10);
    return {w[479:0], w0 + s0 + w9 + s1};
  endfunction

  function automatic state_t state_add(input state_t x, input state_t y);
    state_t r;
    for (int i = 0; i < 8; i++) begin
      r[i*32 +: 32] = x[i*32 +: 32] + y[i*32 +: 32];
    end
    return r;
  endfunction

endpackage
`default_nettype wire

FILE: rtl/block_header_double_sha256_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// block_header_double_sha256_unit: double SHA-256 of a block header
// Serializes the header, runs three chained compression pipelines and
// returns the byte-reversed digest.
// ----------------------------------------------------------------------------
// Usage:
//   Slave channel s_axis_*: one header item per accept, fields packed in
//   s_axis_tdata (640 bits). Master channel m_axis_*: one digest item of
//   256 bits per header, in the order headers were accepted.
//   Pipeline: 3 x 65 register stages plus the output register, 196 stages in
//   all; the accepting edge loads the first.
//   Throughput: one item per cycle while the receiver does not stall, set by
//   one SHA-256 round per stage in each of the three compression pipelines
//   (two for the 80-byte header, one for the 32-byte first digest).
//   Reset clears all valid bits; payload registers hold stale data.
//   When the receiver stalls, each stage holds its item; empty stages keep
//   filling, so s_axis_tready drops only once the whole pipe is full.
// ----------------------------------------------------------------------------
module block_header_double_sha256_unit (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         s_axis_tvalid,
  output logic              s_axis_tready,
  // version, prev_hash_w0..w3, merkle_w0..w3, time_stamp, target_bits,
  // nonce_word (lowest bit up)
  input  wire logic [639:0] s_axis_tdata,
  output logic              m_axis_tvalid,
  input  wire logic         m_axis_tready,
  // hash_w0, hash_w1, hash_w2, hash_w3 (lowest bit up)
  output logic [255:0]      m_axis_tdata
);

  logic [31:0] version, time_stamp, target_bits, nonce_word;
  logic [255:0] prev_disp, merkle_disp;
  logic [639:0] hdr;
  bhd_pkg::sched_t blk0, blk1, blk2;
  logic [255:0] pv, mk;

  assign version     = s_axis_tdata[31:0];
  assign time_stamp  = s_axis_tdata[575:544];
  assign target_bits = s_axis_tdata[607:576];
  assign nonce_word  = s_axis_tdata[639:608];
  // Display order: word 0 first, its top byte is display byte 0.
  assign pv = s_axis_tdata[287:32];
  assign mk = s_axis_tdata[543:288];
  assign prev_disp   = {pv[63:0], pv[127:64], pv[191:128], pv[255:192]};
  assign merkle_disp = {mk[63:0], mk[127:64], mk[191:128], mk[255:192]};

  // Wire bytes, byte 0 in the top bits.
  always_comb begin
    hdr[639:608] = {version[7:0], version[15:8], version[23:16], version[31:24]};
    for (int i = 0; i < 32; i++) begin
      hdr[607 - 8*i -: 8] = prev_disp[8*i +: 8];
      hdr[351 - 8*i -: 8] = merkle_disp[8*i +: 8];
    end
    hdr[95:64] = {time_stamp[7:0], time_stamp[15:8], time_stamp[23:16], time_stamp[31:24]};
    hdr[63:32] = {target_bits[7:0], target_bits[15:8], target_bits[23:16],
                  target_bits[31:24]};
    hdr[31:0]  = {nonce_word[7:0], nonce_word[15:8], nonce_word[23:16], nonce_word[31:24]};
  end

  assign blk0 = hdr[639:128];

  // Pass 1, block 0; tail words ride beside it.
  logic v1, r1, v2, r2, v3, r3;
  bhd_pkg::state_t s1, s2, s3;
  logic [127:0] tail_q [bhd_pkg::Rounds+1];

  bhd_compress u_c0 (
    .clk_i, .rst_ni,
    .valid_i(s_axis_tvalid), .ready_o(s_axis_tready),
    .state_i(bhd_pkg::Iv), .block_i(blk0),
    .valid_o(v1), .ready_i(r1), .state_o(s1)
  );

  // Tail delay line matched to u_c0 stages, with enables built the same way.
  logic tadv [bhd_pkg::Rounds+1];
  logic tv_q [bhd_pkg::Rounds+1];
  always_comb begin
    tadv[bhd_pkg::Rounds] = !tv_q[bhd_pkg::Rounds] || r1;
    for (int i = bhd_pkg::Rounds - 1; i >= 0; i--) tadv[i] = !tv_q[i] || tadv[i+1];
  end
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i <= bhd_pkg::Rounds; i++) tv_q[i] <= 1'b0;
    end else begin
      if (tadv[0]) tv_q[0] <= s_axis_tvalid;
      for (int i = 1; i <= bhd_pkg::Rounds; i++) if (tadv[i]) tv_q[i] <= tv_q[i-1];
    end
  end
  always_ff @(posedge clk_i) begin
    if (tadv[0]) tail_q[0] <= hdr[127:0];
    for (int i = 1; i <= bhd_pkg::Rounds; i++) if (tadv[i]) tail_q[i] <= tail_q[i-1];
  end

  // Block 1: 16 tail bytes, pad, length 640 bits.
  assign blk1 = {tail_q[bhd_pkg::Rounds], 32'h80000000, 320'h0, 32'h280};

  bhd_compress u_c1 (
    .clk_i, .rst_ni,
    .valid_i(v1), .ready_o(r1),
    .state_i(s1), .block_i(blk1),
    .valid_o(v2), .ready_i(r2), .state_o(s2)
  );

  // Pass 2: 32-byte digest, pad, length 256 bits.
  assign blk2 = {s2, 32'h80000000, 192'h0, 32'h100};

  bhd_compress u_c2 (
    .clk_i, .rst_ni,
    .valid_i(v2), .ready_o(r2),
    .state_i(bhd_pkg::Iv), .block_i(blk2),
    .valid_o(v3), .ready_i(r3), .state_o(s3)
  );

  // Output register; reverse digest bytes into display order.
  logic         ov_q;
  logic [255:0] od_q, rev;
  always_comb begin
    for (int i = 0; i < 32; i++) rev[8*i +: 8] = s3[8*i +: 8];
  end
  assign r3 = !ov_q || m_axis_tready;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) ov_q <= 1'b0;
    else if (r3) ov_q <= v3;
  end
  // Display byte 8j+k = digest byte 31-8j-k; hash_wj top byte first.
  always_ff @(posedge clk_i) begin
    if (r3 && v3) begin
      for (int j = 0; j < 4; j++) begin
        for (int k = 0; k < 8; k++) begin
          od_q[64*j + 63 - 8*k -: 8] <= rev[8*(8*j + k) +: 8];
        end
      end
    end
  end
  assign m_axis_tvalid = ov_q;
  assign m_axis_tdata  = od_q;

  // Tail line stays in lockstep with the first compression unit.
  a_tail_sync: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tv_q[bhd_pkg::Rounds] == v1) else $error("tail line out of step");
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("output dropped under stall");
  a_ready_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> v1) else $error("input stalled with pipe not full");

endmodule
`default_nettype wire

FILE: rtl/bhd_compress.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bhd_compress: pipelined SHA-256 compression
// A capture stage, then 64 round stages, the last with the feed-forward add.
// A full stage holds while the stage after it cannot load (per-stage enable).
// ----------------------------------------------------------------------------
module bhd_compress (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            valid_i,
  output logic                 ready_o,
  input  wire bhd_pkg::state_t state_i,
  input  wire bhd_pkg::sched_t block_i,
  output logic                 valid_o,
  input  wire logic            ready_i,
  output bhd_pkg::state_t      state_o
);

  localparam int unsigned N = bhd_pkg::Rounds;

  logic            vld_q [N+1];
  bhd_pkg::state_t st_q  [N+1];
  bhd_pkg::state_t iv_q  [N+1];
  bhd_pkg::sched_t w_q   [N+1];
  logic            adv   [N+1];

  // Stage i may load when it is empty or being drained.
  always_comb begin
    adv[N] = !vld_q[N] || ready_i;
    for (int i = N - 1; i >= 0; i--) begin
      adv[i] = !vld_q[i] || adv[i+1];
    end
  end

  assign ready_o = adv[0];
  assign valid_o = vld_q[N];
  assign state_o = st_q[N];

  // Valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i <= N; i++) vld_q[i] <= 1'b0;
    end else begin
      if (adv[0]) vld_q[0] <= valid_i;
      for (int i = 1; i <= N; i++) begin
        if (adv[i]) vld_q[i] <= vld_q[i-1];
      end
    end
  end

  // Stage 0 captures input; stages 1..64 each run one round; stage 64
  // also adds the feed-forward value to its result.
  always_ff @(posedge clk_i) begin
    if (adv[0]) begin
      st_q[0] <= state_i;
      iv_q[0] <= state_i;
      w_q[0]  <= block_i;
    end
    for (int i = 1; i < N; i++) begin
      if (adv[i]) begin
        st_q[i] <= bhd_pkg::sha_round(st_q[i-1], bhd_pkg::k_of(6'(i-1)), w_q[i-1][511:480]);
        iv_q[i] <= iv_q[i-1];
        w_q[i]  <= bhd_pkg::sched_next(w_q[i-1]);
      end
    end
    if (adv[N]) begin
      st_q[N] <= bhd_pkg::state_add(iv_q[N-1],
        bhd_pkg::sha_round(st_q[N-1], bhd_pkg::k_of(6'(N-1)), w_q[N-1][511:480]));
      iv_q[N] <= iv_q[N-1];
      w_q[N]  <= w_q[N-1];
    end
  end

endmodule
`default_nettype wire

FILE: verif/block_header_double_sha256_unit_test.sv
`default_nettype none
// ----------------------------------------------------------------------------
// block_header_double_sha256_unit_test: self-checking bench for the header
// double hash. Headers go in on the slave stream and digests come out on the
// master stream. A behavioral SHA-256 computes each expected digest not known
// in advance; all are queued in order and compared word by word with the
// output. The run steps through several idling phases on both sides.
// ----------------------------------------------------------------------------
module block_header_double_sha256_unit_test;

  typedef struct packed {
    logic [31:0] nonce_word;
    logic [31:0] target_bits;
    logic [31:0] time_stamp;
    logic [63:0] merkle_w3, merkle_w2, merkle_w1, merkle_w0;
    logic [63:0] prev_hash_w3, prev_hash_w2, prev_hash_w1, prev_hash_w0;
    logic [31:0] version;
  } header_t;

  typedef struct packed {
    logic [63:0] hash_w3, hash_w2, hash_w1, hash_w0;
  } digest_t;

  localparam int unsigned RandomHeaders = 1630;
  localparam int unsigned StallLimit    = 20000;
  localparam int unsigned DrainCycles   = 400;

  logic         clk_i;
  logic         rst_ni;
  logic         s_axis_tvalid;
  logic         s_axis_tready;
  logic [639:0] s_axis_tdata;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [255:0] m_axis_tdata;

  digest_t     digest_q[$];
  header_t     header_rows[$];
  digest_t     known_rows[$];
  bit          known_valid[$];
  int unsigned send_idle_pct;
  int unsigned recv_stall_pct;
  int unsigned idle_cycles = 0;
  bit          failed = 1'b0;

  block_header_double_sha256_unit dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  localparam logic [31:0] RoundK [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
    32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
    32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
    32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
    32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
    32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  function automatic logic [31:0] ror32(input logic [31:0] x, input int n);
    return (x >> n) | (x << (32 - n));
  endfunction

  // One 512-bit block into the chaining value; blk word 0 in the top bits.
  function automatic logic [255:0] compress(input logic [255:0] chain, input logic [511:0] blk);
    logic [31:0] w[64];
    logic [31:0] v[8];
    logic [31:0] t1, t2, s0, s1;
    logic [255:0] res;
    for (int i = 0; i < 16; i++) w[i] = blk[511 - 32*i -: 32];
    for (int i = 16; i < 64; i++) begin
      s0 = ror32(w[i-15], 7) ^ ror32(w[i-15], 18) ^ (w[i-15] >> 3);
      s1 = ror32(w[i-2], 17) ^ ror32(w[i-2], 19) ^ (w[i-2] >> 10);
      w[i] = w[i-16] + s0 + w[i-7] + s1;
    end
    for (int i = 0; i < 8; i++) v[i] = chain[255 - 32*i -: 32];
    for (int i = 0; i < 64; i++) begin
      t1 = v[7] + (ror32(v[4], 6) ^ ror32(v[4], 11) ^ ror32(v[4], 25))
           + ((v[4] & v[5]) ^ (~v[4] & v[6])) + RoundK[i] + w[i];
      t2 = (ror32(v[0], 2) ^ ror32(v[0], 13) ^ ror32(v[0], 22))
           + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
      v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
      v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
    end
    for (int i = 0; i < 8; i++) res[255 - 32*i -: 32] = chain[255 - 32*i -: 32] + v[i];
    return res;
  endfunction

  function automatic logic [31:0] swap32(input logic [31:0] x);
    return {x[7:0], x[15:8], x[23:16], x[31:24]};
  endfunction

  // Serialize the header (wire byte 0 in the top bits), hash twice, reverse.
  function automatic digest_t header_digest(input header_t h);
    logic [639:0] wire_bytes;
    logic [255:0] prev_disp, merk_disp, first, second;
    logic [1023:0] msg;
    logic [511:0] blk2;
    digest_t d;
    prev_disp = {h.prev_hash_w0, h.prev_hash_w1, h.prev_hash_w2, h.prev_hash_w3};
    merk_disp = {h.merkle_w0, h.merkle_w1, h.merkle_w2, h.merkle_w3};
    wire_bytes = {swap32(h.version), {<<8{prev_disp}}, {<<8{merk_disp}},
                  swap32(h.time_stamp), swap32(h.target_bits), swap32(h.nonce_word)};
    msg = {wire_bytes, 8'h80, 312'd0, 64'd640};
    first = compress(bhd_pkg::Iv, msg[1023:512]);
    first = compress(first, msg[511:0]);
    blk2 = {first, 8'h80, 184'd0, 64'd256};
    second = compress(bhd_pkg::Iv, blk2);
    second = {<<8{second}};
    d.hash_w0 = second[255:192];
    d.hash_w1 = second[191:128];
    d.hash_w2 = second[127:64];
    d.hash_w3 = second[63:0];
    return d;
  endfunction

  function automatic header_t random_header();
    header_t h;
    for (int i = 0; i < 20; i++) h[32*i +: 32] = $urandom();
    // occasional all-zero or all-one fields
    if ($urandom_range(0, 15) == 0) begin
      for (int i = 0; i < 20; i++)
        if ($urandom_range(0, 3) == 0) h[32*i +: 32] = $urandom_range(0, 1) ? '1 : '0;
    end
    return h;
  endfunction

  task automatic add_row(input header_t h, input bit known, input digest_t d);
    header_rows.push_back(h);
    known_valid.push_back(known);
    known_rows.push_back(d);
  endtask

  // Sender: one header per accept with random idling.
  task automatic send_header(input header_t h, input bit known, input digest_t d);
    while (send_idle_pct != 0 && $urandom_range(0, 99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= h;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    digest_q.push_back(known ? d : header_digest(h));
  endtask

  // Receiver readiness
  always @(posedge clk_i) begin
    if (recv_stall_pct != 0 && $urandom_range(0, 99) < recv_stall_pct)
      m_axis_tready <= 1'b0;
    else
      m_axis_tready <= 1'b1;
  end

  // Digest checker and watchdog
  always @(posedge clk_i) begin
    digest_t got, want;
    if (rst_ni) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= StallLimit) begin
        $display("block_header_double_sha256_unit regression: fail");
        $finish;
      end
      if (m_axis_tvalid && m_axis_tready) begin
        got = m_axis_tdata;
        if (digest_q.size() == 0) begin
          $error("digest with no header pending: %h", m_axis_tdata);
          failed = 1'b1;
        end else begin
          want = digest_q.pop_front();
          if (got.hash_w0 !== want.hash_w0) begin
            $error("hash_w0 expected %h got %h", want.hash_w0, got.hash_w0);
            failed = 1'b1;
          end
          if (got.hash_w1 !== want.hash_w1) begin
            $error("hash_w1 expected %h got %h", want.hash_w1, got.hash_w1);
            failed = 1'b1;
          end
          if (got.hash_w2 !== want.hash_w2) begin
            $error("hash_w2 expected %h got %h", want.hash_w2, got.hash_w2);
            failed = 1'b1;
          end
          if (got.hash_w3 !== want.hash_w3) begin
            $error("hash_w3 expected %h got %h", want.hash_w3, got.hash_w3);
            failed = 1'b1;
          end
        end
      end
    end
  end

  initial begin
    header_t h;
    digest_t none;
    digest_t genesis;
    int unsigned wait_cycles;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    none           = '0;
    rst_ni         = 1'b0;
    s_axis_tvalid  = 1'b0;
    s_axis_tdata   = '0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed rows: genesis header has a well-known digest.
    h = '0;
    h.version     = 32'd1;
    h.merkle_w0   = 64'h4a5e1e4baab89f3a;
    h.merkle_w1   = 64'h32518a88c31bc87f;
    h.merkle_w2   = 64'h618f76673e2cc77a;
    h.merkle_w3   = 64'hb2127b7afdeda33b;
    h.time_stamp  = 32'h495fab29;
    h.target_bits = 32'h1d00ffff;
    h.nonce_word  = 32'h7c2bac1d;
    genesis.hash_w0 = 64'h000000000019d668;
    genesis.hash_w1 = 64'h9c085ae165831e93;
    genesis.hash_w2 = 64'h4ff763ae46a2a6c1;
    genesis.hash_w3 = 64'h72b3f1b60a8ce26f;
    add_row(h, 1'b1, genesis);
    add_row('0, 1'b0, none);
    add_row('1, 1'b0, none);
    for (int f = 0; f < 20; f++) begin
      h = '0;
      h[32*f +: 32] = (f % 2) ? 32'h8000_0001 : 32'hffff_ffff;
      add_row(h, 1'b0, none);
    end
    for (int r = 0; r < header_rows.size(); r++)
      send_header(header_rows[r], known_valid[r], known_rows[r]);

    // Random headers over the idling phases; the first and last run back-to-back
    for (int n = 0; n < RandomHeaders; n++) begin
      case ((n * 5) / RandomHeaders)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 51; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 51; end
        3: begin send_idle_pct = 35; recv_stall_pct = 35; end
        default: begin send_idle_pct = 0; recv_stall_pct = 0; end
      endcase
      send_header(random_header(), 1'b0, none);
    end
    s_axis_tvalid <= 1'b0;

    // Drain
    wait_cycles = 0;
    while (digest_q.size() != 0 && wait_cycles < 50 * StallLimit) begin
      @(posedge clk_i);
      wait_cycles++;
    end
    repeat (DrainCycles) @(posedge clk_i);
    if (!failed && digest_q.size() == 0) begin
      $display("block_header_double_sha256_unit regression: pass");
    end else begin
      if (digest_q.size() != 0) $error("%0d digests never arrived", digest_q.size());
      $display("block_header_double_sha256_unit regression: fail");
    end
    $finish;
  end

endmodule
`default_nettype wire
